// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file ahf_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AHF_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AHF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ahf_pkg.sv =====
package ahf_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int CFG_DATA_BITS   = 10;
    localparam int LIMIT_BITS      = 6;
    localparam int COUNT_BITS      = 8;
    localparam int CFG_INDEX_BITS  = 3;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_BAND_WIDTH     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_LIMIT    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_JUMP_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_LEVEL      = 3'd3;

    // reset values
    localparam logic [CFG_DATA_BITS-1:0] BAND_WIDTH_RST     = 10'd20;
    localparam logic [LIMIT_BITS-1:0]    COUNT_LIMIT_RST    = 6'd10;
    localparam logic [CFG_DATA_BITS-1:0] JUMP_THRESHOLD_RST = 10'd120;
    localparam logic [CFG_DATA_BITS-1:0] TOP_LEVEL_RST      = 10'd1021;

    // persistence counter saturation bounds
    localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] band_width;
        logic [LIMIT_BITS-1:0]    count_limit;
        logic [CFG_DATA_BITS-1:0] jump_threshold;
        logic [CFG_DATA_BITS-1:0] top_level;
    } cfg_t;

endpackage

// ===== rtl/core/adc_hysteresis_filter.sv =====
// A sample passes through the input register and then the result register to result valid.
// Throughput: one sample per cycle; the held value and persistence counter update in
//   combinational compare/increment logic, so back-to-back samples stall only while
//   a waiting result is back-pressured.
// Reset (aresetn low, synchronous): held value and counter clear to zero, registers load
//   their defaults (band 20, limit 10, jump 120, top 1021), both stages empty.
module adc_hysteresis_filter #(
    parameter int SAMPLE_BITS = ahf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [ahf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ahf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    // sample input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [SAMPLE_BITS-1:0]             s_sample,
    // filtered output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [SAMPLE_BITS-1:0]             m_filtered
);

    // Signed compare width: covers held value +/- any 10-bit register without wrap.
    localparam int CmpW = ((SAMPLE_BITS > ahf_pkg::CFG_DATA_BITS) ?
                           SAMPLE_BITS : ahf_pkg::CFG_DATA_BITS) + 2;
    localparam int CntW = ahf_pkg::COUNT_BITS;
    localparam int LimW = ahf_pkg::LIMIT_BITS;
    localparam logic [SAMPLE_BITS-1:0] FullVal = '1;
    localparam logic signed [CntW-1:0] CntOne = CntW'(1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    ahf_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.band_width     <= ahf_pkg::BAND_WIDTH_RST;
            cfg_reg.count_limit    <= ahf_pkg::COUNT_LIMIT_RST;
            cfg_reg.jump_threshold <= ahf_pkg::JUMP_THRESHOLD_RST;
            cfg_reg.top_level      <= ahf_pkg::TOP_LEVEL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ahf_pkg::REG_BAND_WIDTH:     cfg_reg.band_width     <= cfg_wdata;
                ahf_pkg::REG_COUNT_LIMIT:    cfg_reg.count_limit    <= cfg_wdata[LimW-1:0];
                ahf_pkg::REG_JUMP_THRESHOLD: cfg_reg.jump_threshold <= cfg_wdata;
                ahf_pkg::REG_TOP_LEVEL:      cfg_reg.top_level      <= cfg_wdata;
                default: ; // unmapped index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register -> filter logic -> result register.
    // The filter step fires when a sample is staged and the result
    // register is empty or being drained this cycle.
    // ------------------------------------------------------------------
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] filtered_reg;
    logic                   out_free;
    logic                   fire;

    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_sample;
        end
    end

    // ------------------------------------------------------------------
    // Filter state
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0]  held_reg;
    logic [SAMPLE_BITS-1:0]  held_next;
    logic signed [CntW-1:0]  count_reg;
    logic signed [CntW-1:0]  count_next;

    // widened signed operands
    logic signed [CmpW-1:0]  s_w;
    logic signed [CmpW-1:0]  h_w;
    logic signed [CmpW-1:0]  bw_w;
    logic signed [CmpW-1:0]  jt_w;
    logic signed [CmpW-1:0]  tl_w;
    logic signed [CntW-1:0]  lim_s;
    logic signed [CntW-1:0]  lim_neg;

    logic                    above;
    logic                    below;
    logic [SAMPLE_BITS-1:0]  h_step;   // after the persistence step
    logic [SAMPLE_BITS-1:0]  h_up;     // after the first jump test
    logic [SAMPLE_BITS-1:0]  h_jump;   // after both jump tests
    logic signed [CmpW-1:0]  h_step_w;
    logic signed [CmpW-1:0]  h_up_w;

    assign s_w     = $signed(CmpW'(sample_reg));
    assign h_w     = $signed(CmpW'(held_reg));
    assign bw_w    = $signed(CmpW'(cfg_reg.band_width));
    assign jt_w    = $signed(CmpW'(cfg_reg.jump_threshold));
    assign tl_w    = $signed(CmpW'(cfg_reg.top_level));
    assign lim_s   = $signed(CntW'(cfg_reg.count_limit));
    assign lim_neg = -lim_s;

    // sample at or past the dead band edge on either side
    assign above = s_w >= (h_w + bw_w);
    assign below = s_w <= (h_w - bw_w);

    // Persistence step: count toward the side, step held value once the
    // count is past the limit (saturating at both ends).
    always_comb begin
        h_step     = held_reg;
        count_next = count_reg;
        if (above && (count_reg > lim_s)) begin
            h_step     = (held_reg == FullVal) ? FullVal : held_reg + 1'b1;
            count_next = '0;
        end else if (above) begin
            count_next = (count_reg == ahf_pkg::COUNT_MAX) ? count_reg : count_reg + CntOne;
        end else if (below && (count_reg < lim_neg)) begin
            h_step     = (held_reg == '0) ? '0 : held_reg - 1'b1;
            count_next = '0;
        end else if (below) begin
            count_next = (count_reg == ahf_pkg::COUNT_MIN) ? count_reg : count_reg - CntOne;
        end
    end

    // Jump-follow: far-off sample replaces the held value. The downward
    // test sees the result of the upward one.
    assign h_step_w = $signed(CmpW'(h_step));
    assign h_up     = (s_w > (h_step_w + jt_w)) ? sample_reg : h_step;
    assign h_up_w   = $signed(CmpW'(h_up));
    assign h_jump   = (s_w < (h_up_w - jt_w)) ? sample_reg : h_up;

    // Snaps: top level wins over the zero snap; zero snap uses the new count.
    always_comb begin
        held_next = h_jump;
        if (s_w >= tl_w) begin
            held_next = FullVal;
        end else if ((sample_reg == '0) && (count_next < lim_s)) begin
            held_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            count_reg <= '0;
        end else if (fire) begin
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            filtered_reg <= held_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_filtered = filtered_reg;

endmodule

// ===== rtl/core/ahf_chk.sv =====
`include "assert_macros.svh"

module ahf_chk #(
    parameter int SAMPLE_BITS = ahf_pkg::SAMPLE_BITS_DEF
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [SAMPLE_BITS-1:0] m_filtered
);

    // stalled result holds its value
    `AHF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_filtered))

    // result stage is empty right after reset
    `AHF_ASSERT_SAME(a_rst_empty, aclk, aresetn, $rose(aresetn), !m_valid)

    // a downstream that is ready never back-pressures the input
    `AHF_ASSERT_SAME(a_ready_flow, aclk, aresetn, m_ready, s_ready)

    // a new result comes from an input transaction that passed the input register, then the result register
    `AHF_ASSERT_SAME(a_latency, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready, 2))

endmodule

bind adc_hysteresis_filter ahf_chk #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_ahf_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_filtered(m_filtered)
);
